// ----- hdl/gaussian_blob_pixel_blend_macros.svh -----
`ifndef GAUSSIAN_BLOB_PIXEL_BLEND_MACROS_SVH
`define GAUSSIAN_BLOB_PIXEL_BLEND_MACROS_SVH

// Same-cycle implication on aclk, checked outside reset.
`define GBPB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gbpb: same-cycle check failed");

// Next-cycle implication on aclk, checked outside reset.
`define GBPB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gbpb: next-cycle check failed");

`endif

// ----- hdl/gbpb_pkg.sv -----
package gbpb_pkg;

    // Exponential table: exp(-s) for s in [0, 16), Q0.16.
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_W           = 16;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PATCH_WIDTH  = 3'd0,
        CFG_PATCH_HEIGHT = 3'd1,
        CFG_AMPLITUDE    = 3'd2,
        CFG_INV_RADIUS_X = 3'd3,
        CFG_INV_RADIUS_Y = 3'd4,
        CFG_COLOR_RED    = 3'd5,
        CFG_COLOR_GREEN  = 3'd6,
        CFG_COLOR_BLUE   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } pix_out_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef logic [EXP_W-1:0] exp_table_t [EXP_TABLE_DEPTH];

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    // Division of a series term by its (small, fixed) index.
    function automatic logic [63:0] div_by_term(input logic [63:0] x, input int i);
        logic [63:0] q;
        case (i)
            1:  q = x / 1;
            2:  q = x / 2;
            3:  q = x / 3;
            4:  q = x / 4;
            5:  q = x / 5;
            6:  q = x / 6;
            7:  q = x / 7;
            8:  q = x / 8;
            9:  q = x / 9;
            10: q = x / 10;
            11: q = x / 11;
            12: q = x / 12;
            13: q = x / 13;
            14: q = x / 14;
            15: q = x / 15;
            16: q = x / 16;
            17: q = x / 17;
            18: q = x / 18;
            19: q = x / 19;
            20: q = x / 20;
            21: q = x / 21;
            22: q = x / 22;
            23: q = x / 23;
            24: q = x / 24;
            default: q = x;
        endcase
        return q;
    endfunction

    // exp(-f) for f in Q.30, 0 <= f <= 1.0, by a 24-term Taylor series; result Q.30.
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        longint      acc;
        logic [63:0] term;
        acc  = longint'(Q30_ONE);
        term = Q30_ONE;
        for (int i = 1; i <= 24; i++) begin
            term = div_by_term((term * f) >> 30, i);
            if (i[0]) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    // Evaluated at elaboration only.
    function automatic exp_table_t build_exp_table();
        exp_table_t  tbl;
        logic [63:0] e1;
        logic [63:0] num;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] ew;
        logic [63:0] v;
        logic [63:0] q;
        e1 = exp_neg_frac(Q30_ONE);
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            num   = 64'(16 * k);
            whole = num / EXP_TABLE_DEPTH;
            rem   = num % EXP_TABLE_DEPTH;
            frac  = (rem << 30) / EXP_TABLE_DEPTH;
            ew    = Q30_ONE;
            for (logic [63:0] n = 64'd0; n < whole; n++) begin
                ew = (ew * e1 + Q30_HALF) >> 30;
            end
            v = (ew * exp_neg_frac(frac) + Q30_HALF) >> 30;
            q = (v + 64'd8192) >> 14;
            tbl[k] = (q > 64'd65535) ? 16'hFFFF : q[EXP_W-1:0];
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// ----- hdl/gaussian_blob_pixel_blend.sv -----
// Blends a stream of base pixels with a Gaussian blob of a programmable colour. One pixel
// transfer is accepted every clock while s_ready is high, and its result passes through the
// nine register stages (offset, radius scaling, squaring, saturated sum, table index,
// registered exponential ROM read, amplitude product, alpha clamp, channel blend), the first
// of which is loaded at the accepting edge itself.
// Each stage holds its item only while the stage after it is full, so a stalled output
// still lets the pipeline fill up behind it. Configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata and must only be changed while no pixel is in flight; indexes
// are, in order, the patch width, the patch height, amplitude, inv_radius_x, inv_radius_y,
// color_red, color_green, color_blue. The exponential table is a constant ROM and needs no
// fill time.
`include "gaussian_blob_pixel_blend_macros.svh"

module gaussian_blob_pixel_blend (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gbpb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gbpb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gbpb_pkg::pix_in_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output gbpb_pkg::pix_out_t              m_data
);

    localparam int NUM_STAGES = 9;
    localparam int ST_MAG     = 0;
    localparam int ST_SCALE   = 1;
    localparam int ST_SQUARE  = 2;
    localparam int ST_SUM     = 3;
    localparam int ST_INDEX   = 4;
    localparam int ST_ROM     = 5;
    localparam int ST_AMP     = 6;
    localparam int ST_ALPHA   = 7;
    localparam int ST_OUT     = 8;

    localparam int SCALE_W   = 24;
    localparam int SQUARE_W  = 2 * SCALE_W;
    localparam int SUM_SHIFT = 28;
    localparam int SUM_W     = SUM_SHIFT + 1;
    localparam int IDX_PROD_W = SUM_W + gbpb_pkg::EXP_IDX_W + 1;
    localparam int IDX_WIDE_W = IDX_PROD_W - SUM_SHIFT;
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(1) << SUM_SHIFT;
    localparam int AMP_PROD_W = 12 + gbpb_pkg::EXP_W;
    localparam int ALPHA_PROD_W = AMP_PROD_W + 8;

    // Configuration registers.
    logic [8:0]  blob_cols_reg;
    logic [8:0]  blob_rows_reg;
    logic [11:0] amplitude_reg;
    logic [15:0] inv_radius_x_reg;
    logic [15:0] inv_radius_y_reg;
    logic [7:0]  color_red_reg;
    logic [7:0]  color_green_reg;
    logic [7:0]  color_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blob_cols_reg    <= 9'd40;
            blob_rows_reg    <= 9'd40;
            amplitude_reg    <= 12'd512;
            inv_radius_x_reg <= 16'd410;
            inv_radius_y_reg <= 16'd273;
            color_red_reg    <= 8'd255;
            color_green_reg  <= 8'd0;
            color_blue_reg   <= 8'd0;
        end else if (cfg_we) begin
            case (gbpb_pkg::cfg_index_t'(cfg_addr))
                gbpb_pkg::CFG_PATCH_WIDTH:  blob_cols_reg    <= cfg_wdata[8:0];
                gbpb_pkg::CFG_PATCH_HEIGHT: blob_rows_reg    <= cfg_wdata[8:0];
                gbpb_pkg::CFG_AMPLITUDE:    amplitude_reg    <= cfg_wdata[11:0];
                gbpb_pkg::CFG_INV_RADIUS_X: inv_radius_x_reg <= cfg_wdata;
                gbpb_pkg::CFG_INV_RADIUS_Y: inv_radius_y_reg <= cfg_wdata;
                gbpb_pkg::CFG_COLOR_RED:    color_red_reg    <= cfg_wdata[7:0];
                gbpb_pkg::CFG_COLOR_GREEN:  color_green_reg  <= cfg_wdata[7:0];
                gbpb_pkg::CFG_COLOR_BLUE:   color_blue_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads whenever it is empty or its successor loads.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_ready;

    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_ready[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[ST_OUT];

    // The base pixel travels alongside the alpha computation.
    gbpb_pkg::rgb_t pix_reg [ST_OUT];

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            pix_reg[0] <= '{red: s_data.base_red, green: s_data.base_green,
                            blue: s_data.base_blue};
        end
        for (int i = 1; i < ST_OUT; i++) begin
            if (stage_ready[i]) begin
                pix_reg[i] <= pix_reg[i-1];
            end
        end
    end

    // Offset magnitudes from the patch centre.
    logic [7:0] centre_x;
    logic [7:0] centre_y;
    logic [7:0] mag_x_next;
    logic [7:0] mag_y_next;
    logic [7:0] mag_x_reg;
    logic [7:0] mag_y_reg;

    assign centre_x   = blob_cols_reg[8:1];
    assign centre_y   = blob_rows_reg[8:1];
    assign mag_x_next = (centre_x >= s_data.col) ? (centre_x - s_data.col)
                                                 : (s_data.col - centre_x);
    assign mag_y_next = (centre_y >= s_data.row) ? (centre_y - s_data.row)
                                                 : (s_data.row - centre_y);

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_MAG]) begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
        end
    end

    // Scaling by the reciprocal radii, Q.12.
    logic [SCALE_W-1:0] sx_reg;
    logic [SCALE_W-1:0] sy_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_SCALE]) begin
            sx_reg <= SCALE_W'(mag_x_reg) * SCALE_W'(inv_radius_x_reg);
            sy_reg <= SCALE_W'(mag_y_reg) * SCALE_W'(inv_radius_y_reg);
        end
    end

    // Squares, Q.24.
    logic [SQUARE_W-1:0] sqx_reg;
    logic [SQUARE_W-1:0] sqy_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_SQUARE]) begin
            sqx_reg <= SQUARE_W'(sx_reg) * SQUARE_W'(sx_reg);
            sqy_reg <= SQUARE_W'(sy_reg) * SQUARE_W'(sy_reg);
        end
    end

    // Sum of squares, saturated at 16.0.
    logic [SQUARE_W:0] sum_full;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;

    assign sum_full = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign sum_next = (sum_full > (SQUARE_W+1)'(SUM_LIMIT)) ? SUM_LIMIT
                                                             : sum_full[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_SUM]) begin
            sum_reg <= sum_next;
        end
    end

    // Table index; exactly 16.0 lands one past the end and takes the last entry.
    logic [IDX_PROD_W-1:0]          idx_prod;
    logic [IDX_WIDE_W-1:0]          idx_wide;
    logic [gbpb_pkg::EXP_IDX_W-1:0] idx_next;
    logic [gbpb_pkg::EXP_IDX_W-1:0] idx_reg;

    assign idx_prod = IDX_PROD_W'(sum_reg) * IDX_PROD_W'(gbpb_pkg::EXP_TABLE_DEPTH);
    assign idx_wide = idx_prod[IDX_PROD_W-1:SUM_SHIFT];
    assign idx_next = (idx_wide >= IDX_WIDE_W'(gbpb_pkg::EXP_TABLE_DEPTH))
                    ? gbpb_pkg::EXP_IDX_W'(gbpb_pkg::EXP_TABLE_DEPTH - 1)
                    : idx_wide[gbpb_pkg::EXP_IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_INDEX]) begin
            idx_reg <= idx_next;
        end
    end

    // Exponential lookup.
    logic [gbpb_pkg::EXP_W-1:0] rom_data;

    gbpb_exp_rom u_exp_rom (
        .aclk    (aclk),
        .rd_en   (stage_ready[ST_ROM]),
        .rd_addr (idx_reg),
        .rd_data (rom_data)
    );

    // Amplitude times table value.
    logic [AMP_PROD_W-1:0] amp_prod_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_AMP]) begin
            amp_prod_reg <= AMP_PROD_W'(amplitude_reg) * AMP_PROD_W'(rom_data);
        end
    end

    // Times 255, drop the 24 fraction bits, clamp to a byte.
    logic [ALPHA_PROD_W-1:0] alpha_prod;
    logic [ALPHA_PROD_W-25:0] alpha_wide;
    logic [7:0]               alpha_next;
    logic [7:0]               alpha_reg;

    assign alpha_prod = {amp_prod_reg, 8'd0} - ALPHA_PROD_W'(amp_prod_reg);
    assign alpha_wide = alpha_prod[ALPHA_PROD_W-1:24];
    assign alpha_next = (alpha_wide > (ALPHA_PROD_W-24)'(255)) ? 8'hFF : alpha_wide[7:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_ALPHA]) begin
            alpha_reg <= alpha_next;
        end
    end

    // Channel blend and output register.
    function automatic logic [7:0] blend(input logic [7:0] base, input logic [7:0] colour,
                                         input logic [7:0] alpha);
        logic [15:0] mix;
        mix = 16'(base) * 16'(8'd255 - alpha) + 16'(colour) * 16'(alpha);
        return mix[15:8];
    endfunction

    gbpb_pkg::pix_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_OUT]) begin
            out_reg.out_red   <= blend(pix_reg[ST_ALPHA].red, color_red_reg, alpha_reg);
            out_reg.out_green <= blend(pix_reg[ST_ALPHA].green, color_green_reg, alpha_reg);
            out_reg.out_blue  <= blend(pix_reg[ST_ALPHA].blue, color_blue_reg, alpha_reg);
        end
    end

    assign m_data = out_reg;

    // An empty output stage must open the whole chain back to the input.
    `GBPB_ASSERT_IMP(a_empty_tail_ready, !valid_reg[ST_OUT], s_ready)
    // A full stage that moves on must land in its successor.
    `GBPB_ASSERT_NXT(a_sum_moves, valid_reg[ST_SQUARE] && stage_ready[ST_SUM], valid_reg[ST_SUM])
    // The saturated sum never exceeds 16.0.
    `GBPB_ASSERT_IMP(a_sum_limit, valid_reg[ST_SUM], sum_reg <= SUM_LIMIT)
    // A held ROM stage keeps its read data.
    `GBPB_ASSERT_NXT(a_rom_hold, valid_reg[ST_ROM] && !stage_ready[ST_ROM], $stable(rom_data))

endmodule

// ----- hdl/gbpb_exp_rom.sv -----
module gbpb_exp_rom (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [gbpb_pkg::EXP_IDX_W-1:0] rd_addr,
    output logic [gbpb_pkg::EXP_W-1:0]     rd_data
);

    logic [gbpb_pkg::EXP_W-1:0] rd_data_reg;

    // Registered read; the output holds while the read enable is low.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= gbpb_pkg::EXP_TABLE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
